[hdl/broes_pkg.sv]
// ----------------------------------------------------------------------------
// broes_pkg
// Shared types, constants and the mosaic table for the ROI event statistics.
// ----------------------------------------------------------------------------
package broes_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    localparam int FUNC_W     = 3;
    localparam int COORD_W    = 10;
    localparam int CODE_W     = 8;
    localparam int PAT_W      = 2;
    localparam int CNT_W      = 21;
    localparam int HIST_W     = 11;
    localparam int CHAN_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int NUM_CHAN    = 5;
    localparam int NUM_KIND    = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};
    localparam logic [CHAN_W-1:0] CH_ALL   = 3'd4;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_CNT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RD_ROW = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RD_COL = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_BOTTOM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAYER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ON_CODE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_CODE   = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_PIXEL,
        OP_RD_CNT,
        OP_RD_ROW,
        OP_RD_COL,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ON,
        KIND_OFF,
        KIND_ALL
    } kind_t;

    // classified transaction; row/col carry the read index for histogram reads
    typedef struct packed {
        op_t                op;
        logic [CHAN_W-1:0]  chan;
        kind_t              kind;
        logic               cnt_en;
        logic               hist_en;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } op_item_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // channel by [pattern][{row odd, col odd}]: GBRG, BGGR, RGGB, GRBG
    localparam logic [3:0][3:0][1:0] MOSAIC_MAP = {
        {2'd0, 2'd1, 2'd2, 2'd3},
        {2'd1, 2'd0, 2'd3, 2'd2},
        {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd2, 2'd1, 2'd0}
    };

    function automatic logic [1:0] mosaic_channel(input logic [PAT_W-1:0] pattern,
                                                  input logic [1:0] pos);
        return MOSAIC_MAP[pattern][pos];
    endfunction

endpackage

[hdl/broes_in_if.sv]
// ----------------------------------------------------------------------------
// broes_in_if
// Command / pixel channel: valid-ready with the input payload.
// ----------------------------------------------------------------------------
interface broes_in_if;
    import broes_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [CODE_W-1:0]  pixel_code;
    logic [COORD_W-1:0] read_index;

    modport source (output valid, func, pixel_row, pixel_col, pixel_code, read_index,
                    input ready);
    modport sink (input valid, func, pixel_row, pixel_col, pixel_code, read_index,
                  output ready);
endinterface

[hdl/broes_out_if.sv]
// ----------------------------------------------------------------------------
// broes_out_if
// Result channel: valid-ready with the result payload.
// ----------------------------------------------------------------------------
interface broes_out_if;
    import broes_pkg::*;

    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  none_count;
    logic [CNT_W-1:0]  on_count;
    logic [CNT_W-1:0]  off_count;
    logic [CNT_W-1:0]  event_count;
    logic [HIST_W-1:0] hist_count;
    logic              index_bad;

    modport source (output valid, none_count, on_count, off_count, event_count,
                    hist_count, index_bad, input ready);
    modport sink (input valid, none_count, on_count, off_count, event_count,
                  hist_count, index_bad, output ready);
endinterface

[hdl/broes_front.sv]
// ----------------------------------------------------------------------------
// broes_front
// Configuration registers, input handshake and command classification.
// ----------------------------------------------------------------------------
module broes_front #(
    parameter int MAX_ROWS = broes_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = broes_pkg::MAX_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [broes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [broes_pkg::CFG_DATA_W-1:0] cfg_data,
    broes_in_if.sink                         req,
    input  logic                             queue_full,
    input  broes_pkg::back_status_t          status,
    output logic                             push,
    output broes_pkg::op_item_t              item
);
    import broes_pkg::*;

    logic [COORD_W-1:0] top_reg;
    logic [COORD_W-1:0] bottom_reg;
    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] right_reg;
    logic [PAT_W-1:0]   pattern_reg;
    logic [CODE_W-1:0]  on_code_reg;
    logic [CODE_W-1:0]  off_code_reg;

    logic row_in;
    logic col_in;
    logic in_roi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= '0;
            bottom_reg   <= '1;
            left_reg     <= '0;
            right_reg    <= '1;
            pattern_reg  <= '0;
            on_code_reg  <= 8'd1;
            off_code_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROI_TOP:    top_reg      <= cfg_data[COORD_W-1:0];
                REG_ROI_BOTTOM: bottom_reg   <= cfg_data[COORD_W-1:0];
                REG_ROI_LEFT:   left_reg     <= cfg_data[COORD_W-1:0];
                REG_ROI_RIGHT:  right_reg    <= cfg_data[COORD_W-1:0];
                REG_BAYER:      pattern_reg  <= cfg_data[PAT_W-1:0];
                REG_ON_CODE:    on_code_reg  <= cfg_data[CODE_W-1:0];
                REG_OFF_CODE:   off_code_reg <= cfg_data[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign req.ready = !queue_full && !status.init_busy;
    assign push      = req.valid && req.ready;

    // inside the rectangle and inside the histogram arrays
    assign row_in = (req.pixel_row >= top_reg) && (req.pixel_row <= bottom_reg)
                    && (int'(req.pixel_row) < MAX_ROWS);
    assign col_in = (req.pixel_col >= left_reg) && (req.pixel_col <= right_reg)
                    && (int'(req.pixel_col) < MAX_COLS);
    assign in_roi = row_in && col_in;

    always_comb
    begin
        item     = '0;
        item.op  = OP_NOP;
        item.row = req.pixel_row;
        item.col = req.pixel_col;
        case (req.func)
            FUNC_CLEAR:
            begin
                item.op = OP_CLEAR;
            end
            FUNC_PIXEL:
            begin
                item.op   = OP_PIXEL;
                item.chan = {1'b0, mosaic_channel(pattern_reg,
                                                  {req.pixel_row[0], req.pixel_col[0]})};
                // priority: no event, then on, then off
                if (req.pixel_code == '0)
                begin
                    item.kind   = KIND_NONE;
                    item.cnt_en = in_roi;
                end
                else if (req.pixel_code == on_code_reg)
                begin
                    item.kind    = KIND_ON;
                    item.cnt_en  = in_roi;
                    item.hist_en = in_roi;
                end
                else if (req.pixel_code == off_code_reg)
                begin
                    item.kind    = KIND_OFF;
                    item.cnt_en  = in_roi;
                    item.hist_en = in_roi;
                end
            end
            FUNC_RD_CNT:
            begin
                item.chan = req.read_index[CHAN_W-1:0];
                if (req.read_index > COORD_W'(CH_ALL))
                    item.op = OP_BAD;
                else
                    item.op = OP_RD_CNT;
            end
            FUNC_RD_ROW:
            begin
                item.row = req.read_index;
                if (int'(req.read_index) >= MAX_ROWS)
                    item.op = OP_BAD;
                else
                    item.op = OP_RD_ROW;
            end
            FUNC_RD_COL:
            begin
                item.col = req.read_index;
                if (int'(req.read_index) >= MAX_COLS)
                    item.op = OP_BAD;
                else
                    item.op = OP_RD_COL;
            end
            default:
            begin
                item.op = OP_NOP;
            end
        endcase
    end

endmodule

[hdl/broes_fifo.sv]
// ----------------------------------------------------------------------------
// broes_fifo
// Short queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module broes_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  broes_pkg::op_item_t item,
    output logic                full,
    input  logic                pop,
    output broes_pkg::op_item_t head,
    output logic                head_valid
);
    import broes_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_item_t         store [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= item;
    end

endmodule

[hdl/broes_back.sv]
// ----------------------------------------------------------------------------
// broes_back
// Channel counters, row/column histogram memories, clearing sweep and the
// result register.
// ----------------------------------------------------------------------------
module broes_back #(
    parameter int MAX_ROWS = broes_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = broes_pkg::MAX_COLS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  broes_pkg::op_item_t     head,
    input  logic                    head_valid,
    output logic                    pop,
    output broes_pkg::back_status_t status,
    broes_out_if.source             rsp
);
    import broes_pkg::*;

    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int SWEEP_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SWEEP_W   = $clog2(SWEEP_LEN);

    // channel counters
    logic [CNT_W-1:0] cnt_reg  [NUM_CHAN][NUM_KIND];
    logic [CNT_W-1:0] cnt_next [NUM_CHAN][NUM_KIND];

    // histogram memories
    logic [HIST_W-1:0] row_mem [MAX_ROWS];
    logic [HIST_W-1:0] col_mem [MAX_COLS];
    logic [HIST_W-1:0] row_rd_reg;
    logic [HIST_W-1:0] col_rd_reg;

    // second stage
    logic             b2_valid_reg;
    op_item_t         b2_item_reg;
    logic [CNT_W-1:0] b2_cnt_reg [NUM_KIND];
    logic             b2_leave;

    // clearing sweep
    logic               sweep_active_reg;
    logic [SWEEP_W-1:0] sweep_cnt_reg;
    logic               init_busy_reg;
    logic               sweep_last;

    // last histogram write, forwarded to a read issued on the same edge
    logic              row_fwd_valid_reg;
    logic [ROW_AW-1:0] row_fwd_addr_reg;
    logic [HIST_W-1:0] row_fwd_data_reg;
    logic              col_fwd_valid_reg;
    logic [COL_AW-1:0] col_fwd_addr_reg;
    logic [HIST_W-1:0] col_fwd_data_reg;

    logic              pop_clear;
    logic              pop_pixel;
    logic [ROW_AW-1:0] row_ra;
    logic [COL_AW-1:0] col_ra;
    logic [ROW_AW-1:0] b2_row_addr;
    logic [COL_AW-1:0] b2_col_addr;
    logic [HIST_W-1:0] row_cur;
    logic [HIST_W-1:0] col_cur;
    logic [HIST_W-1:0] row_inc;
    logic [HIST_W-1:0] col_inc;
    logic              hist_upd;
    logic              row_we;
    logic              col_we;
    logic [ROW_AW-1:0] row_wa;
    logic [COL_AW-1:0] col_wa;
    logic [HIST_W-1:0] row_wd;
    logic [HIST_W-1:0] col_wd;

    // result register
    logic              rsp_valid_reg;
    logic [CNT_W-1:0]  none_next;
    logic [CNT_W-1:0]  on_next;
    logic [CNT_W-1:0]  off_next;
    logic [CNT_W-1:0]  event_next;
    logic [HIST_W-1:0] hist_next;
    logic              bad_next;
    logic [CNT_W-1:0]  none_reg;
    logic [CNT_W-1:0]  on_reg;
    logic [CNT_W-1:0]  off_reg;
    logic [CNT_W-1:0]  event_reg;
    logic [HIST_W-1:0] hist_reg;
    logic              bad_reg;

    assign status.init_busy = init_busy_reg;

    // a clear waits in stage two until its sweep is done
    assign b2_leave  = b2_valid_reg && !sweep_active_reg && (!rsp_valid_reg || rsp.ready);
    assign pop       = head_valid && !sweep_active_reg && (!b2_valid_reg || b2_leave);
    assign pop_clear = pop && (head.op == OP_CLEAR);
    assign pop_pixel = pop && (head.op == OP_PIXEL) && head.cnt_en;

    // ---- channel counters, updated as the transaction leaves the queue ----
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            for (int k = 0; k < NUM_KIND; k++)
            begin
                cnt_next[c][k] = cnt_reg[c][k];
                if (pop_clear)
                    cnt_next[c][k] = '0;
                else if (pop_pixel
                         && ((CHAN_W'(c) == head.chan) || (CHAN_W'(c) == CH_ALL))
                         && ((2'(k) == head.kind) || ((2'(k) == KIND_ALL) && head.hist_en))
                         && (cnt_reg[c][k] != CNT_MAX))
                    cnt_next[c][k] = cnt_reg[c][k] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                for (int k = 0; k < NUM_KIND; k++)
                    cnt_reg[c][k] <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                for (int k = 0; k < NUM_KIND; k++)
                    cnt_reg[c][k] <= cnt_next[c][k];
        end
    end

    // ---- stage two ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b2_valid_reg <= 1'b0;
        else if (pop)
            b2_valid_reg <= 1'b1;
        else if (b2_leave)
            b2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b2_item_reg <= head;
            if (head.op == OP_RD_CNT)
                for (int k = 0; k < NUM_KIND; k++)
                    b2_cnt_reg[k] <= cnt_reg[head.chan][k];
        end
    end

    // ---- histogram memories ----
    assign row_ra      = ROW_AW'(head.row);
    assign col_ra      = COL_AW'(head.col);
    assign b2_row_addr = ROW_AW'(b2_item_reg.row);
    assign b2_col_addr = COL_AW'(b2_item_reg.col);

    assign row_cur = (row_fwd_valid_reg && (row_fwd_addr_reg == b2_row_addr))
                     ? row_fwd_data_reg : row_rd_reg;
    assign col_cur = (col_fwd_valid_reg && (col_fwd_addr_reg == b2_col_addr))
                     ? col_fwd_data_reg : col_rd_reg;
    assign row_inc = (row_cur == HIST_MAX) ? row_cur : row_cur + 1'b1;
    assign col_inc = (col_cur == HIST_MAX) ? col_cur : col_cur + 1'b1;

    assign hist_upd = b2_leave && (b2_item_reg.op == OP_PIXEL) && b2_item_reg.hist_en;

    assign row_we = (sweep_active_reg && (int'(sweep_cnt_reg) < MAX_ROWS)) || hist_upd;
    assign col_we = (sweep_active_reg && (int'(sweep_cnt_reg) < MAX_COLS)) || hist_upd;
    assign row_wa = sweep_active_reg ? ROW_AW'(sweep_cnt_reg) : b2_row_addr;
    assign col_wa = sweep_active_reg ? COL_AW'(sweep_cnt_reg) : b2_col_addr;
    assign row_wd = sweep_active_reg ? '0 : row_inc;
    assign col_wd = sweep_active_reg ? '0 : col_inc;

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wa] <= row_wd;
        if (pop)
            row_rd_reg <= row_mem[row_ra];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[col_wa] <= col_wd;
        if (pop)
            col_rd_reg <= col_mem[col_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_fwd_valid_reg <= 1'b0;
            col_fwd_valid_reg <= 1'b0;
        end
        else if (sweep_active_reg)
        begin
            row_fwd_valid_reg <= 1'b0;
            col_fwd_valid_reg <= 1'b0;
        end
        else if (hist_upd)
        begin
            row_fwd_valid_reg <= 1'b1;
            col_fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_upd)
        begin
            row_fwd_addr_reg <= b2_row_addr;
            row_fwd_data_reg <= row_inc;
            col_fwd_addr_reg <= b2_col_addr;
            col_fwd_data_reg <= col_inc;
        end
    end

    // ---- clearing sweep: after reset and for every clear command ----
    assign sweep_last = (sweep_cnt_reg == SWEEP_W'(SWEEP_LEN-1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
            init_busy_reg    <= 1'b1;
        end
        else if (sweep_active_reg)
        begin
            if (sweep_last)
            begin
                sweep_active_reg <= 1'b0;
                sweep_cnt_reg    <= '0;
                init_busy_reg    <= 1'b0;
            end
            else
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
        end
        else if (pop_clear)
        begin
            sweep_active_reg <= 1'b1;
        end
    end

    // ---- result ----
    always_comb
    begin
        none_next  = '0;
        on_next    = '0;
        off_next   = '0;
        event_next = '0;
        hist_next  = '0;
        bad_next   = 1'b0;
        case (b2_item_reg.op)
            OP_RD_CNT:
            begin
                none_next  = b2_cnt_reg[KIND_NONE];
                on_next    = b2_cnt_reg[KIND_ON];
                off_next   = b2_cnt_reg[KIND_OFF];
                event_next = b2_cnt_reg[KIND_ALL];
            end
            OP_RD_ROW: hist_next = row_cur;
            OP_RD_COL: hist_next = col_cur;
            OP_BAD:    bad_next  = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (b2_leave)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b2_leave)
        begin
            none_reg  <= none_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            event_reg <= event_next;
            hist_reg  <= hist_next;
            bad_reg   <= bad_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.none_count  = none_reg;
    assign rsp.on_count    = on_reg;
    assign rsp.off_count   = off_reg;
    assign rsp.event_count = event_reg;
    assign rsp.hist_count  = hist_reg;
    assign rsp.index_bad   = bad_reg;

endmodule

[hdl/bayer_roi_event_statistics.sv]
// ----------------------------------------------------------------------------
// bayer_roi_event_statistics
// Region-of-interest event statistics for a Bayer event-camera sensor.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  req       in         valid / ready        func, pixel_row, pixel_col,
//                                            pixel_code, read_index
//  rsp       out        valid / ready        none/on/off/event counts,
//                                            hist_count, index_bad
//  cfg       in         cfg_we (no stall)    cfg_index, cfg_data
//
//  One transaction per clock sustained while no sweep runs and rsp is ready;
//  each request gives one response, passing the queue, the counter/memory
//  read stage and the response register. The histogram memories' single
//  write port sets the cost of a clear: a sweep over max(MAX_ROWS, MAX_COLS)
//  addresses, in which responses stop while requests still fill the queue.
//  After reset the same sweep zeroes both memories; req.ready stays low until
//  it ends. A stall on rsp holds the response register, then the second
//  stage, then the queue, and only then req.ready.
//
// Front: config registers and classification of each request (ROI test,
// mosaic channel, event kind, index range). Queue: four entries. Back:
// saturating channel counters in flip-flops, row and column histograms in
// RAM with read-modify-write and one-deep write forwarding.
// ----------------------------------------------------------------------------
module bayer_roi_event_statistics #(
    parameter int MAX_ROWS = broes_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = broes_pkg::MAX_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [broes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [broes_pkg::CFG_DATA_W-1:0] cfg_data,
    broes_in_if.sink                         req,
    broes_out_if.source                      rsp
);
    import broes_pkg::*;

    op_item_t     front_item;
    logic         push;
    logic         queue_full;
    op_item_t     head;
    logic         head_valid;
    logic         pop;
    back_status_t status;

    // classify requests; ready is held low only by a full queue or the
    // initial clearing sweep
    broes_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .queue_full (queue_full),
        .status     (status),
        .push       (push),
        .item       (front_item)
    );

    // decouples the front from memory sweeps and output stalls
    broes_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (front_item),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // counters, histograms and the response register
    broes_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .status     (status),
        .rsp        (rsp)
    );

endmodule
